[src/sme_pkg.sv]
// Shared types and codes for the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

   localparam logic [4:0] MODE_PUSH_IMM  = 5'd0;
   localparam logic [4:0] MODE_PUSH_REG  = 5'd1;
   localparam logic [4:0] MODE_PUSH_RIND = 5'd2;
   localparam logic [4:0] MODE_PUSH_RAM  = 5'd3;
   localparam logic [4:0] MODE_POP_REG   = 5'd4;
   localparam logic [4:0] MODE_POP_RIND  = 5'd5;
   localparam logic [4:0] MODE_POP_RAM   = 5'd6;
   localparam logic [4:0] MODE_ADD       = 5'd7;
   localparam logic [4:0] MODE_MUL       = 5'd8;
   localparam logic [4:0] MODE_SUB       = 5'd9;
   localparam logic [4:0] MODE_DIV       = 5'd10;
   localparam logic [4:0] MODE_SQRT      = 5'd11;
   localparam logic [4:0] MODE_JAE       = 5'd12;
   localparam logic [4:0] MODE_JA        = 5'd13;
   localparam logic [4:0] MODE_JB        = 5'd14;
   localparam logic [4:0] MODE_JBE       = 5'd15;
   localparam logic [4:0] MODE_JE        = 5'd16;
   localparam logic [4:0] MODE_JNE       = 5'd17;
   localparam logic [4:0] MODE_JUMP      = 5'd18;
   localparam logic [4:0] MODE_CALL      = 5'd19;
   localparam logic [4:0] MODE_RET       = 5'd20;
   localparam logic [4:0] MODE_IN        = 5'd21;
   localparam logic [4:0] MODE_OUT       = 5'd22;
   localparam logic [4:0] MODE_END       = 5'd23;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_HALT  = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_DIVZ  = 3'd4;
   localparam logic [2:0] ST_CALL  = 3'd5;
   localparam logic [2:0] ST_ADDR  = 3'd6;
   localparam logic [2:0] ST_ROOT  = 3'd7;

   localparam logic [1:0] ITER_MUL  = 2'd0;
   localparam logic [1:0] ITER_DIV  = 2'd1;
   localparam logic [1:0] ITER_SQRT = 2'd2;

   typedef struct packed {
      logic [4:0]         mode;
      logic signed [31:0] imm;
      logic [3:0]         reg_index;
      logic [9:0]         ram_addr;
      logic [15:0]        target;
      logic [15:0]        next_addr;
      logic [1:0]         need;
      logic               grows;
   } entry_type;

endpackage
`default_nettype wire

[src/sme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[src/sme_front.sv]
// Front end: accepts instructions, classifies stack use, and queues them.
`timescale 1ns / 1ps
`default_nettype none
module sme_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               init_done,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [4:0]         req_mode,
   input  wire logic signed [31:0] req_imm,
   input  wire logic [3:0]         req_reg_index,
   input  wire logic [9:0]         req_ram_addr,
   input  wire logic [15:0]        req_target,
   input  wire logic [15:0]        req_next_addr,
   output logic                    q_valid,
   input  wire logic               q_ready,
   output sme_pkg::entry_type      q_entry
);
   import sme_pkg::*;

   entry_type ent_ff [2];
   entry_type ent_in;
   logic      wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic      push, pop;

   always_comb begin
      ent_in.mode      = req_mode;
      ent_in.imm       = req_imm;
      ent_in.reg_index = req_reg_index;
      ent_in.ram_addr  = req_ram_addr;
      ent_in.target    = req_target;
      ent_in.next_addr = req_next_addr;
      ent_in.need      = 2'd0;
      if (req_mode == MODE_OUT || req_mode == MODE_SQRT ||
          (req_mode >= MODE_POP_REG && req_mode <= MODE_POP_RAM)) begin
         ent_in.need = 2'd1;
      end else if (req_mode >= MODE_ADD && req_mode <= MODE_JNE) begin
         ent_in.need = 2'd2;
      end
      ent_in.grows = (req_mode <= MODE_PUSH_RAM) || (req_mode == MODE_IN);
   end

   assign req_ready = init_done && (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_entry   = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= ent_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

[src/sme_mdu.sv]
// Iterative multiply, signed divide and integer square root unit.
`timescale 1ns / 1ps
`default_nettype none
module sme_mdu #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            op,
   input  wire logic [DATA_WIDTH-1:0] a,
   input  wire logic [DATA_WIDTH-1:0] b,
   output logic                       done,
   output logic      [DATA_WIDTH-1:0] result
);
   import sme_pkg::*;

   localparam int DW     = DATA_WIDTH;
   localparam int CW     = $clog2(DW + 1);
   localparam int BITTOP = 2 * ((DW - 1) / 2);

   logic [DW-1:0] acc_ff, x_ff, y_ff;
   logic [CW-1:0] cnt_ff;
   logic [1:0]    op_ff;
   logic          run_ff, done_ff, neg_ff;
   logic [DW:0]   t, sum;

   assign t   = {acc_ff, x_ff[DW-1]};
   assign sum = {1'b0, acc_ff} + {1'b0, y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         op_ff   <= op;
         acc_ff  <= '0;
         cnt_ff  <= CW'(DW);
         neg_ff  <= a[DW-1] ^ b[DW-1];
         unique case (op)
            ITER_MUL: begin
               x_ff <= a;
               y_ff <= b;
            end
            ITER_DIV: begin
               x_ff <= a[DW-1] ? (~a + 1'b1) : a;
               y_ff <= b[DW-1] ? (~b + 1'b1) : b;
            end
            default: begin
               x_ff <= b;
               y_ff <= DW'(1) << BITTOP;
            end
         endcase
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         unique case (op_ff)
            ITER_MUL: begin
               if (y_ff[0]) acc_ff <= acc_ff + x_ff;
               x_ff <= x_ff << 1;
               y_ff <= y_ff >> 1;
               if (cnt_ff == CW'(1)) begin
                  run_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
            ITER_DIV: begin
               if (t >= {1'b0, y_ff}) begin
                  acc_ff <= DW'(t - {1'b0, y_ff});
                  x_ff   <= {x_ff[DW-2:0], 1'b1};
               end else begin
                  acc_ff <= t[DW-1:0];
                  x_ff   <= {x_ff[DW-2:0], 1'b0};
               end
               if (cnt_ff == CW'(1)) begin
                  run_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
            default: begin
               if ({1'b0, x_ff} >= sum) begin
                  x_ff   <= x_ff - sum[DW-1:0];
                  acc_ff <= (acc_ff >> 1) + y_ff;
               end else begin
                  acc_ff <= acc_ff >> 1;
               end
               y_ff <= y_ff >> 2;
               if (y_ff < DW'(4)) begin
                  run_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         endcase
      end
   end

   assign done = done_ff;

   always_comb begin
      unique case (op_ff)
         ITER_MUL: result = acc_ff;
         ITER_DIV: result = neg_ff ? (~x_ff + 1'b1) : x_ff;
         default:  result = acc_ff;
      endcase
   end
endmodule
`default_nettype wire

[src/sme_back.sv]
// Back end: reads operands, executes one instruction, and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module sme_back #(
   parameter int STACK_DEPTH = 64,
   parameter int CALL_DEPTH  = 16,
   parameter int NUM_REGS    = 16,
   parameter int RAM_WORDS   = 1024,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   output logic                     q_ready,
   input  wire sme_pkg::entry_type  q_entry,
   output logic                     init_done,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [15:0]              rsp_next_ip,
   output logic                     rsp_out_valid,
   output logic signed [31:0]       rsp_out_value,
   output logic [2:0]               rsp_status
);
   import sme_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int RSW = $clog2(CALL_DEPTH + 1);
   localparam int RIW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
   localparam int RGW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int DAW = $clog2(RAM_WORDS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDA  = 3'd1;
   localparam logic [2:0] S_RDB  = 3'd2;
   localparam logic [2:0] S_RDC  = 3'd3;
   localparam logic [2:0] S_EXEC = 3'd4;
   localparam logic [2:0] S_ITER = 3'd5;

   logic [2:0]     state_ff, state_in;
   entry_type      cur_ff;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [RSW-1:0] rsp_cnt_ff;
   logic [15:0]    rs_ff [CALL_DEPTH];
   logic [DW-1:0]  regs_ff [NUM_REGS];
   logic           halted_ff;
   logic [DW-1:0]  top_ff, sec_ff;
   logic [DAW-1:0] clr_cnt_ff;
   logic           init_done_ff;

   logic [SAW-1:0] s_raddr, s_waddr;
   logic [DW-1:0]  s_rdata, s_wdata, d_rdata, d_wdata_mux;
   logic           s_we_raw, s_we;
   logic [DAW-1:0] d_addr, d_waddr_mux;
   logic           d_we_raw, d_we;

   logic           out_free, fin, commit, go_iter;
   logic [1:0]     iter_op;
   logic           mdu_done;
   logic [DW-1:0]  mdu_res;
   logic [2:0]     st;
   logic [15:0]    nip;
   logic           ovalid;
   logic [31:0]    oval;
   logic           reg_we, rs_push, rs_pop, halt_set;
   logic [DW-1:0]  immw, regv;
   logic [RGW-1:0] ri_idx;
   logic           ri_ok, rind_ok, ra_ok, lt, eq, take;
   logic [SAW-1:0] sp_m1, sp_m2;

   assign out_free = !rsp_valid || rsp_ready;
   assign immw     = DW'($signed(cur_ff.imm));
   assign ri_idx   = RGW'(cur_ff.reg_index);
   assign regv     = regs_ff[ri_idx];
   assign ri_ok    = 32'(cur_ff.reg_index) < NUM_REGS;
   assign rind_ok  = ri_ok && !regv[DW-1] && (65'(regv) < 65'(RAM_WORDS));
   assign ra_ok    = 32'(cur_ff.ram_addr) < RAM_WORDS;
   assign d_addr   = (cur_ff.mode == MODE_PUSH_RIND || cur_ff.mode == MODE_POP_RIND) ?
                     DAW'(regv) : DAW'(cur_ff.ram_addr);
   assign sp_m1    = SAW'(sp_ff - SPW'(1));
   assign sp_m2    = SAW'(sp_ff - SPW'(2));
   assign s_raddr  = (state_ff == S_RDA) ? sp_m1 : sp_m2;
   assign lt       = $signed(sec_ff) < $signed(top_ff);
   assign eq       = sec_ff == top_ff;
   assign q_ready  = (state_ff == S_IDLE) && init_done_ff;
   assign init_done = init_done_ff;

   always_comb begin
      unique case (cur_ff.mode)
         MODE_JAE: take = !lt;
         MODE_JA:  take = !lt && !eq;
         MODE_JB:  take = lt;
         MODE_JBE: take = lt || eq;
         MODE_JE:  take = eq;
         default:  take = !eq;
      endcase
   end

   always_comb begin
      fin      = 1'b0;
      go_iter  = 1'b0;
      iter_op  = ITER_MUL;
      st       = ST_OK;
      nip      = cur_ff.next_addr;
      ovalid   = 1'b0;
      oval     = '0;
      s_we_raw = 1'b0;
      s_waddr  = SAW'(sp_ff);
      s_wdata  = immw;
      sp_in    = sp_ff;
      reg_we   = 1'b0;
      d_we_raw = 1'b0;
      rs_push  = 1'b0;
      rs_pop   = 1'b0;
      halt_set = 1'b0;
      if (state_ff == S_EXEC) begin
         fin = 1'b1;
         priority if (halted_ff) begin
            st = ST_HALT;
         end else if (sp_ff < SPW'(cur_ff.need)) begin
            st = ST_UNDER;
         end else if (cur_ff.grows && (32'(sp_ff) >= STACK_DEPTH)) begin
            st = ST_OVER;
         end else begin
            unique case (cur_ff.mode)
               MODE_PUSH_IMM, MODE_IN: begin
                  s_we_raw = 1'b1;
                  sp_in    = sp_ff + SPW'(1);
               end
               MODE_PUSH_REG: begin
                  if (!ri_ok) st = ST_ADDR;
                  else begin
                     s_we_raw = 1'b1;
                     s_wdata  = regv;
                     sp_in    = sp_ff + SPW'(1);
                  end
               end
               MODE_PUSH_RIND, MODE_PUSH_RAM: begin
                  if ((cur_ff.mode == MODE_PUSH_RIND) ? !rind_ok : !ra_ok) st = ST_ADDR;
                  else begin
                     s_we_raw = 1'b1;
                     s_wdata  = d_rdata;
                     sp_in    = sp_ff + SPW'(1);
                  end
               end
               MODE_POP_REG: begin
                  if (!ri_ok) st = ST_ADDR;
                  else begin
                     reg_we = 1'b1;
                     sp_in  = sp_ff - SPW'(1);
                  end
               end
               MODE_POP_RIND, MODE_POP_RAM: begin
                  if ((cur_ff.mode == MODE_POP_RIND) ? !rind_ok : !ra_ok) st = ST_ADDR;
                  else begin
                     d_we_raw = 1'b1;
                     sp_in    = sp_ff - SPW'(1);
                  end
               end
               MODE_ADD, MODE_SUB: begin
                  s_we_raw = 1'b1;
                  s_waddr  = sp_m2;
                  s_wdata  = (cur_ff.mode == MODE_ADD) ? sec_ff + top_ff : sec_ff - top_ff;
                  sp_in    = sp_ff - SPW'(1);
               end
               MODE_MUL: begin
                  fin     = 1'b0;
                  go_iter = 1'b1;
               end
               MODE_DIV: begin
                  if (top_ff == '0) st = ST_DIVZ;
                  else begin
                     fin     = 1'b0;
                     go_iter = 1'b1;
                     iter_op = ITER_DIV;
                  end
               end
               MODE_SQRT: begin
                  if (top_ff[DW-1]) st = ST_ROOT;
                  else begin
                     fin     = 1'b0;
                     go_iter = 1'b1;
                     iter_op = ITER_SQRT;
                  end
               end
               MODE_JAE, MODE_JA, MODE_JB, MODE_JBE, MODE_JE, MODE_JNE: begin
                  sp_in = sp_ff - SPW'(2);
                  if (take) nip = cur_ff.target;
               end
               MODE_JUMP: nip = cur_ff.target;
               MODE_CALL: begin
                  if (32'(rsp_cnt_ff) >= CALL_DEPTH) st = ST_CALL;
                  else begin
                     rs_push = 1'b1;
                     nip     = cur_ff.target;
                  end
               end
               MODE_RET: begin
                  if (rsp_cnt_ff == '0) st = ST_CALL;
                  else begin
                     rs_pop = 1'b1;
                     nip    = rs_ff[RIW'(rsp_cnt_ff - RSW'(1))];
                  end
               end
               MODE_OUT: begin
                  ovalid = 1'b1;
                  oval   = 32'($signed(top_ff));
                  sp_in  = sp_ff - SPW'(1);
               end
               MODE_END: begin
                  halt_set = 1'b1;
                  st       = ST_HALT;
               end
               default: ;
            endcase
         end
      end else if (state_ff == S_ITER && mdu_done) begin
         fin      = 1'b1;
         s_we_raw = 1'b1;
         s_wdata  = mdu_res;
         if (cur_ff.mode == MODE_SQRT) begin
            s_waddr = sp_m1;
         end else begin
            s_waddr = sp_m2;
            sp_in   = sp_ff - SPW'(1);
         end
      end
   end

   assign commit      = fin && out_free;
   assign s_we        = s_we_raw && commit;
   assign d_we        = !init_done_ff || (d_we_raw && commit);
   assign d_waddr_mux = init_done_ff ? d_addr : clr_cnt_ff;
   assign d_wdata_mux = init_done_ff ? top_ff : '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_valid && q_ready) state_in = S_RDA;
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_RDC;
         S_RDC:  state_in = S_EXEC;
         S_EXEC: begin
            if (go_iter) state_in = S_ITER;
            else if (commit) state_in = S_IDLE;
         end
         S_ITER: if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_ready) cur_ff <= q_entry;
      if (state_ff == S_RDB) top_ff <= s_rdata;
      if (state_ff == S_RDC) sec_ff <= s_rdata;
      if (rs_push && commit) rs_ff[RIW'(rsp_cnt_ff)] <= cur_ff.next_addr;
      if (commit) begin
         rsp_next_ip   <= nip;
         rsp_out_valid <= ovalid;
         rsp_out_value <= oval;
         rsp_status    <= st;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_cnt_ff   <= '0;
         halted_ff    <= 1'b0;
         rsp_valid    <= 1'b0;
         clr_cnt_ff   <= '0;
         init_done_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (!init_done_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == DAW'(RAM_WORDS - 1)) init_done_ff <= 1'b1;
         end
         if (commit) begin
            rsp_valid <= 1'b1;
            sp_ff     <= sp_in;
            if (halt_set) halted_ff <= 1'b1;
            if (rs_push)  rsp_cnt_ff <= rsp_cnt_ff + RSW'(1);
            if (rs_pop)   rsp_cnt_ff <= rsp_cnt_ff - RSW'(1);
            if (reg_we)   regs_ff[ri_idx] <= top_ff;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   sme_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   sme_ram #(.WIDTH(DW), .DEPTH(RAM_WORDS), .AW(DAW)) u_data_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr_mux),
      .wdata (d_wdata_mux),
      .raddr (d_addr),
      .rdata (d_rdata)
   );

   sme_mdu #(.DATA_WIDTH(DW)) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .start  (go_iter),
      .op     (iter_op),
      .a      (sec_ff),
      .b      (top_ff),
      .done   (mdu_done),
      .result (mdu_res)
   );
endmodule
`default_nettype wire

[src/stack_machine_execute_unit.sv]
// Stack machine execute unit: top level joining front end and back end.
// Each instruction passes from the queue head through the back-end states RDA, RDB,
// RDC and EXEC; mul, div and sqrt add an ITER state on the iterative unit.
// The back end takes a new instruction only when idle, as the single stack RAM read
// port fetches top and second in turn; a 2-entry queue decouples input acceptance.
// Reset: synchronous; afterwards the data RAM is cleared word by word over all
// RAM_WORDS addresses, during which req_ready stays low.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute_unit #(
   parameter int STACK_DEPTH = 64,
   parameter int CALL_DEPTH  = 16,
   parameter int NUM_REGS    = 16,
   parameter int RAM_WORDS   = 1024,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [4:0]         req_mode,
   input  wire logic signed [31:0] req_imm,
   input  wire logic [3:0]         req_reg_index,
   input  wire logic [9:0]         req_ram_addr,
   input  wire logic [15:0]        req_target,
   input  wire logic [15:0]        req_next_addr,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_next_ip,
   output logic                    rsp_out_valid,
   output logic signed [31:0]      rsp_out_value,
   output logic [2:0]              rsp_status
);
   import sme_pkg::*;

   entry_type q_entry;
   logic      q_valid, q_ready, init_done;

   sme_front u_front (
      .clock         (clock),
      .reset         (reset),
      .init_done     (init_done),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_imm       (req_imm),
      .req_reg_index (req_reg_index),
      .req_ram_addr  (req_ram_addr),
      .req_target    (req_target),
      .req_next_addr (req_next_addr),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_entry       (q_entry)
   );

   sme_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .CALL_DEPTH  (CALL_DEPTH),
      .NUM_REGS    (NUM_REGS),
      .RAM_WORDS   (RAM_WORDS),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_entry       (q_entry),
      .init_done     (init_done),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_next_ip   (rsp_next_ip),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status)
   );

   a_no_accept_during_clear: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !req_ready) else $error("transaction accepted during RAM clear");

   a_out_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_value == 32'sd0)
      else $error("out_value nonzero without out");

   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == ST_OK)
      else $error("out transaction with error status");
endmodule
`default_nettype wire
